/* sv/kwl_pkg.sv */
// Shared types, constants and character helpers for the keyword token lexer.
// Used by kwl_core, kwl_fifo and keyword_token_lexer; depends on nothing.
`default_nettype none

package kwl_pkg;

    // Token kind codes.
    localparam int KIND_W = 4;
    localparam logic [KIND_W-1:0] K_FN     = 4'd0;
    localparam logic [KIND_W-1:0] K_IDENT  = 4'd1;
    localparam logic [KIND_W-1:0] K_LPAREN = 4'd2;
    localparam logic [KIND_W-1:0] K_VOID   = 4'd3;
    localparam logic [KIND_W-1:0] K_RPAREN = 4'd4;
    localparam logic [KIND_W-1:0] K_LBRACE = 4'd5;
    localparam logic [KIND_W-1:0] K_RETURN = 4'd6;
    localparam logic [KIND_W-1:0] K_NUMBER = 4'd7;
    localparam logic [KIND_W-1:0] K_PLUS   = 4'd8;
    localparam logic [KIND_W-1:0] K_STAR   = 4'd9;
    localparam logic [KIND_W-1:0] K_SEMI   = 4'd10;
    localparam logic [KIND_W-1:0] K_RBRACE = 4'd11;
    localparam logic [KIND_W-1:0] K_END    = 4'd12;
    localparam logic [KIND_W-1:0] K_ERROR  = 4'd13;

    // One source byte gives at most this many tokens.
    localparam int MAX_RESULTS = 3;
    localparam int PUSH_W      = 2;

    // Result queue geometry.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;
    localparam int Q_CNT_W = 4;

    // Keyword candidate index.
    localparam logic [1:0] KW_IDX_FN     = 2'd0;
    localparam logic [1:0] KW_IDX_RETURN = 2'd1;
    localparam logic [1:0] KW_IDX_VOID   = 2'd2;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_let(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_sp(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0A);
    endfunction

    // Expected byte of a keyword at a given matched length.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] prog);
        logic [7:0] r;
        r = 8'h00;
        unique case (k)
            KW_IDX_FN:
            begin
                unique case (prog)
                    3'd0:    r = "f";
                    3'd1:    r = "n";
                    default: r = 8'h00;
                endcase
            end
            KW_IDX_RETURN:
            begin
                unique case (prog)
                    3'd0:    r = "r";
                    3'd1:    r = "e";
                    3'd2:    r = "t";
                    3'd3:    r = "u";
                    3'd4:    r = "r";
                    3'd5:    r = "n";
                    default: r = 8'h00;
                endcase
            end
            KW_IDX_VOID:
            begin
                unique case (prog)
                    3'd0:    r = "v";
                    3'd1:    r = "o";
                    3'd2:    r = "i";
                    3'd3:    r = "d";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] kw_size(input logic [1:0] k);
        logic [2:0] r;
        unique case (k)
            KW_IDX_FN:     r = 3'd2;
            KW_IDX_RETURN: r = 3'd6;
            KW_IDX_VOID:   r = 3'd4;
            default:       r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] kw_kind(input logic [1:0] k);
        logic [KIND_W-1:0] r;
        unique case (k)
            KW_IDX_FN:     r = K_FN;
            KW_IDX_RETURN: r = K_RETURN;
            default:       r = K_VOID;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/kwl_fifo.sv */
// Result queue for the keyword token lexer: takes up to three tokens a cycle,
// gives one a cycle unless the output stalls. Depends on kwl_pkg.
`default_nettype none

module kwl_fifo
    import kwl_pkg::*;
#(
    parameter int W = 38
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [PUSH_W-1:0]             push_n,
    input  wire logic [MAX_RESULTS-1:0][W-1:0] push_data,
    output logic                               space,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [W-1:0]                       out_data
);

    logic [W-1:0]       mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0]    wr_ptr_reg;
    logic [Q_AW-1:0]    wr_ptr_next;
    logic [Q_AW-1:0]    rd_ptr_reg;
    logic [Q_AW-1:0]    rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               pop;

    // The head entry is shown directly; it holds until the transaction completes.
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign space     = (count_reg <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS));

    // Pointer and fill count arithmetic.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_AW'(push_n);
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage; up to three consecutive entries are written per cycle.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (PUSH_W'(i) < push_n)
            begin
                mem[wr_ptr_reg + Q_AW'(i)] <= push_data[i];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/kwl_core.sv */
// Lexer state and the per-byte token logic of the keyword token lexer.
// Depends on kwl_pkg.
`default_nettype none

module kwl_core
    import kwl_pkg::*;
#(
    parameter int POS_BITS = 16,
    parameter int W        = 2 * POS_BITS + 6
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [7:0]                    ch,
    input  wire logic                          last,
    output logic [PUSH_W-1:0]                  push_n,
    output logic [MAX_RESULTS-1:0][W-1:0]      push_data
);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_NUM     = 3'd1,
        M_IDENT   = 3'd2,
        M_KW_FN   = 3'd3,
        M_KW_RET  = 3'd4,
        M_KW_VOID = 3'd5,
        M_DROP    = 3'd6
    } mode_t;

    mode_t               mode_reg;
    mode_t               mode_next;
    logic [2:0]          kp_reg;
    logic [2:0]          kp_next;
    logic [POS_BITS-1:0] rs_reg;
    logic [POS_BITS-1:0] rs_next;
    logic [POS_BITS:0]   rl_reg;
    logic [POS_BITS:0]   rl_next;
    logic [POS_BITS:0]   bp_reg;
    logic [POS_BITS:0]   bp_next;

    logic [POS_BITS-1:0] p;
    mode_t               fr_mode;
    logic                fr_begin;
    logic                fr_emit;
    logic [KIND_W-1:0]   fr_kind;
    logic [1:0]          kw_idx;
    logic                kw_hit;
    logic [2:0]          kp_inc;
    logic                alnum;
    logic [W-1:0]        slot [0:MAX_RESULTS-1];
    logic [PUSH_W-1:0]   n;

    function automatic logic [W-1:0] tok(input logic [KIND_W-1:0] kind,
                                        input logic [POS_BITS-1:0] start,
                                        input logic [POS_BITS:0] len,
                                        input logic eos);
        return {eos, len, start, kind};
    endfunction

    assign p     = bp_reg[POS_BITS-1:0];
    assign alnum = is_dig(ch) || is_let(ch);

    // Classification of a byte that starts a fresh token.
    always_comb
    begin
        fr_mode  = M_IDLE;
        fr_begin = 1'b0;
        fr_emit  = 1'b0;
        fr_kind  = K_ERROR;
        priority if (is_sp(ch))
        begin
            fr_mode = M_IDLE;
        end
        else if (is_dig(ch))
        begin
            fr_mode  = M_NUM;
            fr_begin = 1'b1;
        end
        else if (ch == "f")
        begin
            fr_mode  = M_KW_FN;
            fr_begin = 1'b1;
        end
        else if (ch == "r")
        begin
            fr_mode  = M_KW_RET;
            fr_begin = 1'b1;
        end
        else if (ch == "v")
        begin
            fr_mode  = M_KW_VOID;
            fr_begin = 1'b1;
        end
        else if (is_let(ch))
        begin
            fr_mode  = M_IDENT;
            fr_begin = 1'b1;
        end
        else
        begin
            fr_emit = 1'b1;
            fr_mode = M_IDLE;
            unique case (ch)
                "+":     fr_kind = K_PLUS;
                "*":     fr_kind = K_STAR;
                "(":     fr_kind = K_LPAREN;
                ")":     fr_kind = K_RPAREN;
                "{":     fr_kind = K_LBRACE;
                "}":     fr_kind = K_RBRACE;
                ";":     fr_kind = K_SEMI;
                default:
                begin
                    fr_kind = K_ERROR;
                    fr_mode = M_DROP;
                end
            endcase
        end
    end

    // Keyword candidate matching against the stored progress.
    always_comb
    begin
        unique case (mode_reg)
            M_KW_FN:  kw_idx = KW_IDX_FN;
            M_KW_RET: kw_idx = KW_IDX_RETURN;
            default:  kw_idx = KW_IDX_VOID;
        endcase
        kp_inc = kp_reg + 3'd1;
        kw_hit = (kp_reg < kw_size(kw_idx)) && (ch == kw_char(kw_idx, kp_reg));
    end

    // Next state and the tokens this byte gives, in order.
    always_comb
    begin
        mode_next = mode_reg;
        kp_next   = kp_reg;
        rs_next   = rs_reg;
        rl_next   = rl_reg;
        bp_next   = bp_reg;
        n         = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot[i] = '0;
        end

        if (go)
        begin
            if (mode_reg != M_DROP)
            begin
                if (bp_reg[POS_BITS])
                begin
                    // Source too long: close any pending run, then report it.
                    if (mode_reg == M_NUM)
                    begin
                        slot[n] = tok(K_NUMBER, rs_reg, rl_reg, 1'b0);
                        n = n + 1'b1;
                    end
                    else if (mode_reg != M_IDLE)
                    begin
                        slot[n] = tok(K_IDENT, rs_reg, rl_reg, 1'b0);
                        n = n + 1'b1;
                    end
                    slot[n]   = tok(K_ERROR, '1, '0, 1'b0);
                    n         = n + 1'b1;
                    mode_next = M_DROP;
                    kp_next   = 3'd0;
                end
                else
                begin
                    priority if ((mode_reg == M_NUM && is_dig(ch))
                                 || (mode_reg == M_IDENT && alnum))
                    begin
                        rl_next = rl_reg + 1'b1;
                    end
                    else if ((mode_reg == M_KW_FN || mode_reg == M_KW_RET
                              || mode_reg == M_KW_VOID) && kw_hit)
                    begin
                        kp_next = kp_inc;
                        rl_next = rl_reg + 1'b1;
                        if (kp_inc == kw_size(kw_idx))
                        begin
                            slot[n] = tok(kw_kind(kw_idx), rs_reg,
                                          {{(POS_BITS-2){1'b0}}, kw_size(kw_idx)}, 1'b0);
                            n         = n + 1'b1;
                            mode_next = M_IDLE;
                            kp_next   = 3'd0;
                        end
                    end
                    else if ((mode_reg == M_KW_FN || mode_reg == M_KW_RET
                              || mode_reg == M_KW_VOID) && alnum)
                    begin
                        // A broken keyword carries on as an identifier.
                        mode_next = M_IDENT;
                        kp_next   = 3'd0;
                        rl_next   = rl_reg + 1'b1;
                    end
                    else
                    begin
                        // Close the pending run, then lex this byte afresh.
                        if (mode_reg == M_NUM)
                        begin
                            slot[n] = tok(K_NUMBER, rs_reg, rl_reg, 1'b0);
                            n = n + 1'b1;
                        end
                        else if (mode_reg != M_IDLE)
                        begin
                            slot[n] = tok(K_IDENT, rs_reg, rl_reg, 1'b0);
                            n = n + 1'b1;
                        end
                        mode_next = fr_mode;
                        if (fr_begin)
                        begin
                            rs_next = p;
                            rl_next = {{POS_BITS{1'b0}}, 1'b1};
                            kp_next = 3'd1;
                        end
                        else
                        begin
                            kp_next = 3'd0;
                        end
                        if (fr_emit)
                        begin
                            slot[n] = tok(fr_kind, p, {{POS_BITS{1'b0}}, 1'b1}, 1'b0);
                            n = n + 1'b1;
                        end
                    end
                    bp_next = bp_reg + 1'b1;
                end
            end

            if (last)
            begin
                // End of source: close the run, give the end token, reset.
                if (n != 2'd3)
                begin
                    if (mode_next == M_NUM)
                    begin
                        slot[n] = tok(K_NUMBER, rs_next, rl_next, 1'b0);
                        n = n + 1'b1;
                    end
                    else if (mode_next == M_IDENT || mode_next == M_KW_FN
                             || mode_next == M_KW_RET || mode_next == M_KW_VOID)
                    begin
                        slot[n] = tok(K_IDENT, rs_next, rl_next, 1'b0);
                        n = n + 1'b1;
                    end
                end
                if (n != 2'd3)
                begin
                    slot[n] = tok(K_END, '0, '0, 1'b1);
                    n = n + 1'b1;
                end
                mode_next = M_IDLE;
                kp_next   = 3'd0;
                rs_next   = '0;
                rl_next   = '0;
                bp_next   = '0;
            end
        end
    end

    assign push_n = n;

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            push_data[i] = slot[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            kp_reg   <= 3'd0;
            rs_reg   <= '0;
            rl_reg   <= '0;
            bp_reg   <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            kp_reg   <= kp_next;
            rs_reg   <= rs_next;
            rl_reg   <= rl_next;
            bp_reg   <= bp_next;
        end
    end

endmodule

`default_nettype wire

/* sv/keyword_token_lexer.sv */
// Top level of the keyword token lexer: input register, lexer core and
// result queue. Depends on kwl_pkg, kwl_core and kwl_fifo.
//
//   channel | signals                                              | role
//   --------+------------------------------------------------------+--------
//   in      | in_valid, in_stall, ch, last                         | bytes
//   out     | out_valid, out_stall, token_kind, token_start,       | tokens
//           | token_len, end_of_source                             |
//
// Each byte is registered, then lexed once the queue has room, and its tokens
// (none to three) are written to an eight-entry queue in that same cycle.
// One byte a cycle is taken while the queue has room for three tokens; the
// output port gives one token a cycle unless stalled, so a sustained rate
// of one byte per cycle holds while bytes average at most one token. Reset
// returns the lexer to idle at offset zero and empties the queue. A stall on
// the output only stalls the input once the queue is nearly full.
`default_nettype none

module keyword_token_lexer
    import kwl_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          ch,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [KIND_W-1:0]        token_kind,
    output logic [POS_BITS-1:0]      token_start,
    output logic [POS_BITS:0]        token_len,
    output logic                     end_of_source
);

    localparam int TW = KIND_W + POS_BITS + (POS_BITS + 1) + 1;

    logic                         stage_valid_reg;
    logic                         stage_valid_next;
    logic [7:0]                   ch_reg;
    logic                         last_reg;
    logic                         space;
    logic                         go;
    logic                         accept;
    logic [PUSH_W-1:0]            push_n;
    logic [MAX_RESULTS-1:0][TW-1:0] push_data;
    logic [TW-1:0]                out_data;

    // The held byte is lexed once the queue can take its tokens.
    assign go       = stage_valid_reg && space;
    assign in_stall = stage_valid_reg && !space;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (go)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Input byte register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    kwl_core #(
        .POS_BITS (POS_BITS),
        .W        (TW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .ch        (ch_reg),
        .last      (last_reg),
        .push_n    (push_n),
        .push_data (push_data)
    );

    kwl_fifo #(
        .W (TW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Unpack the queued transaction onto the output ports.
    assign token_kind    = out_data[KIND_W-1:0];
    assign token_start   = out_data[KIND_W +: POS_BITS];
    assign token_len     = out_data[KIND_W + POS_BITS +: POS_BITS + 1];
    assign end_of_source = out_data[TW-1];

endmodule

`default_nettype wire
